>>> rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

  // Geometry of the page map
  localparam int MAX_PAGES = 4096;
  localparam int WORD_W    = 32;
  localparam int ROWS      = MAX_PAGES / WORD_W;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int BIT_AW    = $clog2(WORD_W);
  localparam int PAGE_AW   = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_AW + 1;
  localparam int ROWN_W    = CNT_W - BIT_AW;

  // Field widths fixed by the interface
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // Register reset values
  localparam logic [CFG_W-1:0] PAGE_COUNT_RST = CFG_W'(4096);
  localparam logic [CFG_W-1:0] RESERVED_RST   = CFG_W'(1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'b1;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_t;

  // One row lookup for the free-bit finder
  typedef struct packed {
    logic [ROW_AW-1:0] row;
    logic [CNT_W-1:0]  lo;   // lowest eligible page
    logic [CNT_W-1:0]  hi;   // first page past the range
  } scan_req_t;

  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] bit_idx;
  } scan_res_t;

  // Page count as used: saturated to the map depth
  function automatic logic [CNT_W-1:0] lim_count(input logic [CFG_W-1:0] pc);
    logic [CNT_W-1:0] r;
    if (CNT_W'(pc) > CNT_W'(MAX_PAGES)) r = CNT_W'(MAX_PAGES);
    else r = CNT_W'(pc);
    return r;
  endfunction

  // Reserved count as used: saturated to the page count
  function automatic logic [CNT_W-1:0] lim_res(input logic [CFG_W-1:0] res,
                                               input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    if (CNT_W'(res) > cnt) r = cnt;
    else r = CNT_W'(res);
    return r;
  endfunction

  localparam logic [CNT_W-1:0] LIVE_COUNT_RST = lim_count(PAGE_COUNT_RST);
  localparam logic [CNT_W-1:0] LIVE_RES_RST   = lim_res(RESERVED_RST, LIVE_COUNT_RST);

endpackage

`default_nettype wire

>>> rtl/bpa_map_ram.sv
`default_nettype none

module bpa_map_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [bpa_pkg::ROW_AW-1:0] wr_addr,
  input  wire logic [bpa_pkg::WORD_W-1:0] wr_data,
  input  wire logic [bpa_pkg::ROW_AW-1:0] rd_addr,
  output logic      [bpa_pkg::WORD_W-1:0] rd_data
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/bpa_find_free.sv
`default_nettype none

module bpa_find_free (
  input  wire logic [bpa_pkg::WORD_W-1:0] word,
  input  wire bpa_pkg::scan_req_t         req,
  output bpa_pkg::scan_res_t              res
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] elig;
  logic              lo_row;
  logic              hi_row;

  // Bounds only cut into the row that holds them
  assign lo_row = ({1'b0, req.row} == req.lo[CNT_W-1:BIT_AW]);
  assign hi_row = ({1'b0, req.row} == req.hi[CNT_W-1:BIT_AW]);

  // Free bits inside [lo, hi)
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      elig[b] = !word[b]
              && (!lo_row || (BIT_AW'(b) >= req.lo[BIT_AW-1:0]))
              && (!hi_row || (BIT_AW'(b) <  req.hi[BIT_AW-1:0]));
    end
  end

  // Lowest eligible bit wins
  always_comb begin
    res.found   = |elig;
    res.bit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (elig[b]) res.bit_idx = BIT_AW'(b);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bitmap_page_allocator_unit.sv
// Channel  Direction  Ports                                        Handshake
// -------  ---------  -------------------------------------------  ------------------------
// in       input      in_mode, in_page_index                       start & !busy
// out      output     out_status, out_granted_index, out_used_count out_valid, one cycle
// cfg      input      cfg_index, cfg_wdata                         cfg_we, no wait
//
// Request paths: no-op, full allocate and out-of-range free go straight to the result;
// free reads the map word, then writes it back; init sweeps every map row; other
// allocates step through 32-page map rows, one read of the single map read port per row.
// After reset the map is swept once, row by row, with busy high.
// Register writes act at the next init. The result is a one-cycle strobe that
// the receiver cannot stall.
`default_nettype none

module bitmap_page_allocator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bpa_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [bpa_pkg::PAGE_AW-1:0]   in_page_index,
  output logic                               out_valid,
  output logic      [bpa_pkg::STATUS_W-1:0]  out_status,
  output logic      [bpa_pkg::PAGE_AW-1:0]   out_granted_index,
  output logic      [bpa_pkg::CNT_W-1:0]     out_used_count,
  input  wire logic                          cfg_we,
  input  wire logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpa_pkg::CFG_W-1:0]     cfg_wdata
);
  import bpa_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]    page_count_r;
  logic [CFG_W-1:0]    reserved_r;
  logic [CNT_W-1:0]    live_count_r, live_count_nxt;
  logic [CNT_W-1:0]    live_res_r, live_res_nxt;
  logic [CNT_W-1:0]    pages_used_r, pages_used_nxt;
  logic [PAGE_AW-1:0]  cursor_r, cursor_nxt;
  logic [ROW_AW-1:0]   clr_row_r, clr_row_nxt;
  logic                report_r, report_nxt;
  logic [ROW_AW-1:0]   scan_row_r, scan_row_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [PAGE_AW-1:0]  idx_r, idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [PAGE_AW-1:0]  granted_r, granted_nxt;

  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ROW_AW-1:0]   ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  scan_req_t           sreq;
  scan_res_t           sres;

  logic                accept;
  logic                alloc_ok;
  logic                free_bad;
  logic [PAGE_AW-1:0]  start_page;
  logic                clr_last;
  logic [ROWN_W-1:0]   res_row;
  logic [WORD_W-1:0]   clr_pattern;
  logic [ROWN_W-1:0]   next_row;
  logic                wrap;
  logic [PAGE_AW-1:0]  hit_page;
  logic [CNT_W-1:0]    hit_next;
  logic [CNT_W-1:0]    cfg_count;

  bpa_map_ram u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bpa_find_free u_find (
    .word (ram_rdata),
    .req  (sreq),
    .res  (sres)
  );

  // Request decode
  assign accept   = start && (state_r == S_IDLE);
  assign alloc_ok = (pages_used_r < live_count_r) && (live_res_r < live_count_r);
  assign free_bad = ({1'b0, in_page_index} >= live_count_r)
                 || ({1'b0, in_page_index} <  live_res_r);
  assign cfg_count = lim_count(page_count_r);

  // Scan start: cursor pulled back into the managed range
  assign start_page = (({1'b0, cursor_r} >= live_count_r) || ({1'b0, cursor_r} < live_res_r))
                    ? live_res_r[PAGE_AW-1:0] : cursor_r;

  // Init sweep row pattern
  assign clr_last = (clr_row_r == ROW_AW'(ROWS - 1));
  assign res_row  = live_res_r[CNT_W-1:BIT_AW];
  always_comb begin
    if ({1'b0, clr_row_r} < res_row) clr_pattern = '1;
    else if ({1'b0, clr_row_r} == res_row)
      clr_pattern = ~({WORD_W{1'b1}} << live_res_r[BIT_AW-1:0]);
    else clr_pattern = '0;
  end

  // Finder request and scan stepping
  assign sreq.row = scan_row_r;
  assign sreq.lo  = lo_r;
  assign sreq.hi  = live_count_r;
  assign next_row = {1'b0, scan_row_r} + ROWN_W'(1);
  assign wrap     = ({next_row, {BIT_AW{1'b0}}} >= live_count_r);
  assign hit_page = {scan_row_r, sres.bit_idx};
  assign hit_next = {1'b0, hit_page} + CNT_W'(1);

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= PAGE_COUNT_RST;
      reserved_r   <= RESERVED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_COUNT: page_count_r <= cfg_wdata;
        CFG_RESERVED:   reserved_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_mode)
            MODE_ALLOC: state_nxt = alloc_ok ? S_SCAN : S_DONE;
            MODE_FREE:  state_nxt = free_bad ? S_DONE : S_FREE;
            MODE_INIT:  state_nxt = S_CLEAR;
            MODE_NOP:   state_nxt = S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_last) state_nxt = report_r ? S_DONE : S_IDLE;
      end
      S_SCAN: begin
        if (sres.found) state_nxt = S_DONE;
      end
      S_FREE:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and map port control
  always_comb begin
    live_count_nxt = live_count_r;
    live_res_nxt   = live_res_r;
    pages_used_nxt = pages_used_r;
    cursor_nxt     = cursor_r;
    clr_row_nxt    = clr_row_r;
    report_nxt     = report_r;
    scan_row_nxt   = scan_row_r;
    lo_nxt         = lo_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt  = ST_OK;
          granted_nxt = '0;
          unique case (in_mode)
            MODE_ALLOC: begin
              status_nxt   = ST_FULL;
              scan_row_nxt = start_page[PAGE_AW-1:BIT_AW];
              lo_nxt       = {1'b0, start_page};
              ram_raddr    = start_page[PAGE_AW-1:BIT_AW];
            end
            MODE_FREE: begin
              idx_nxt   = in_page_index;
              ram_raddr = in_page_index[PAGE_AW-1:BIT_AW];
              if (free_bad) status_nxt = ST_RANGE;
            end
            MODE_INIT: begin
              live_count_nxt = cfg_count;
              live_res_nxt   = lim_res(reserved_r, cfg_count);
              clr_row_nxt    = '0;
              report_nxt     = 1'b1;
            end
            MODE_NOP: ;
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_row_r;
        ram_wdata   = clr_pattern;
        clr_row_nxt = clr_row_r + ROW_AW'(1);
        if (clr_last) begin
          pages_used_nxt = live_res_r;
          cursor_nxt     = (live_res_r < live_count_r) ? live_res_r[PAGE_AW-1:0] : '0;
        end
      end
      S_SCAN: begin
        if (sres.found) begin
          ram_we         = 1'b1;
          ram_waddr      = scan_row_r;
          ram_wdata      = ram_rdata | (WORD_W'(1) << sres.bit_idx);
          pages_used_nxt = pages_used_r + CNT_W'(1);
          granted_nxt    = hit_page;
          status_nxt     = ST_OK;
          cursor_nxt     = (hit_next >= live_count_r) ? live_res_r[PAGE_AW-1:0]
                                                      : hit_next[PAGE_AW-1:0];
        end else if (wrap) begin
          scan_row_nxt = res_row[ROW_AW-1:0];
          lo_nxt       = live_res_r;
          ram_raddr    = res_row[ROW_AW-1:0];
        end else begin
          scan_row_nxt = next_row[ROW_AW-1:0];
          ram_raddr    = next_row[ROW_AW-1:0];
        end
      end
      S_FREE: begin
        if (!ram_rdata[idx_r[BIT_AW-1:0]]) begin
          status_nxt = ST_FREE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = idx_r[PAGE_AW-1:BIT_AW];
          ram_wdata      = ram_rdata & ~(WORD_W'(1) << idx_r[BIT_AW-1:0]);
          pages_used_nxt = pages_used_r - CNT_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      live_count_r <= LIVE_COUNT_RST;
      live_res_r   <= LIVE_RES_RST;
      pages_used_r <= LIVE_RES_RST;
      cursor_r     <= (LIVE_RES_RST < LIVE_COUNT_RST) ? LIVE_RES_RST[PAGE_AW-1:0] : '0;
      clr_row_r    <= '0;
      report_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_count_r <= live_count_nxt;
      live_res_r   <= live_res_nxt;
      pages_used_r <= pages_used_nxt;
      cursor_r     <= cursor_nxt;
      clr_row_r    <= clr_row_nxt;
      report_r     <= report_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_row_r <= scan_row_nxt;
    lo_r       <= lo_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
  end

  // Result strobe
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_status        = status_r;
  assign out_granted_index = granted_r;
  assign out_used_count    = pages_used_r;

`ifndef ASSERT_OFF
  // The used count still holds the old geometry's value while the map is swept
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |-> (pages_used_r <= live_count_r))
    else $error("used count above page count");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_res_r <= live_count_r)
    else $error("reserved count above page count");

  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted_index != '0) |->
      (({1'b0, out_granted_index} < live_count_r) &&
       ({1'b0, out_granted_index} >= live_res_r) && out_status == ST_OK))
    else $error("granted page outside managed range");

  a_scan_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ({scan_row_r, {BIT_AW{1'b0}}} < live_count_r[PAGE_AW:0]))
    else $error("scan row past last page");

  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("not ready after result");
`endif

endmodule

`default_nettype wire

>>> sim/bitmap_page_allocator_checker.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [bpa_pkg::MODE_W-1:0]    in_mode,
  input  logic [bpa_pkg::PAGE_AW-1:0]   in_page_index,
  input  logic                          out_valid,
  input  logic [bpa_pkg::STATUS_W-1:0]  out_status,
  input  logic [bpa_pkg::PAGE_AW-1:0]   out_granted_index,
  input  logic [bpa_pkg::CNT_W-1:0]     out_used_count,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending_results,
  output int                            results_checked
);
  import bpa_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_AW-1:0]  granted;
    logic [CNT_W-1:0]    used;
  } page_result_t;

  // Shadow copy of the allocator state
  bit               used_map [MAX_PAGES];
  int unsigned      used_total;
  int unsigned      cursor;
  int unsigned      live_pages;
  int unsigned      live_rsv;
  logic [CFG_W-1:0] cfg_pages;
  logic [CFG_W-1:0] cfg_rsv;

  page_result_t expected_q [$];
  int           fails;
  int           checked;

  // Clear the map and mark the reserved leading pages, latching the registers
  function automatic void reload_map();
    live_pages = (cfg_pages > MAX_PAGES) ? MAX_PAGES : cfg_pages;
    live_rsv   = (cfg_rsv > live_pages) ? live_pages : cfg_rsv;
    for (int i = 0; i < MAX_PAGES; i++) used_map[i] = (i < live_rsv);
    used_total = live_rsv;
    cursor     = (live_rsv < live_pages) ? live_rsv : 0;
  endfunction

  // Apply one request to the shadow state and return the result it produces
  function automatic page_result_t apply_request(input logic [MODE_W-1:0]  mode,
                                                 input logic [PAGE_AW-1:0] idx);
    page_result_t r;
    int unsigned  p;
    bit           found;
    r.status  = ST_OK;
    r.granted = '0;
    found     = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        r.status = ST_FULL;
        if (used_total < live_pages && live_rsv < live_pages) begin
          p = cursor;
          if (p >= live_pages || p < live_rsv) p = live_rsv;
          // next-fit: walk forward, wrapping to the first unreserved page
          for (int n = 0; n < live_pages && !found; n++) begin
            if (!used_map[p]) begin
              used_map[p] = 1'b1;
              used_total++;
              r.granted = PAGE_AW'(p);
              r.status  = ST_OK;
              found     = 1'b1;
            end
            p++;
            if (p >= live_pages) p = live_rsv;
          end
          if (found) cursor = p;
        end
      end
      MODE_FREE: begin
        if (idx >= live_pages || idx < live_rsv) begin
          r.status = ST_RANGE;
        end else if (!used_map[idx]) begin
          r.status = ST_FREE;
        end else begin
          used_map[idx] = 1'b0;
          used_total--;
        end
      end
      MODE_INIT: begin
        reload_map();
      end
      default: begin
      end
    endcase
    r.used = CNT_W'(used_total);
    return r;
  endfunction

  // Track register writes, check results against the oldest prediction, predict new requests
  always @(posedge clk) begin : watch
    page_result_t got;
    page_result_t want;
    if (!rst_n) begin
      cfg_pages = PAGE_COUNT_RST;
      cfg_rsv   = RESERVED_RST;
      reload_map();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PAGE_COUNT) cfg_pages = cfg_wdata;
        else if (cfg_index == CFG_RESERVED) cfg_rsv = cfg_wdata;
      end
      if (out_valid) begin
        got = {out_status, out_granted_index, out_used_count};
        checked++;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("[%0t] unexpected result: status %0d granted %0d used %0d",
                     $time, got.status, got.granted, got.used);
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.used !== want.used) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("[%0t] mismatch: status %0d/%0d granted %0d/%0d used %0d/%0d (exp/got)",
                       $time, want.status, got.status, want.granted, got.granted,
                       want.used, got.used);
          end
        end
      end
      if (start && !busy) expected_q.push_back(apply_request(in_mode, in_page_index));
    end
    pending_results <= expected_q.size();
    fail_count      <= fails;
    results_checked <= checked;
  end

endmodule

>>> sim/bitmap_page_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_unit_tb;
  import bpa_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 140;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 start         = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    in_mode       = MODE_NOP;
  logic [PAGE_AW-1:0]   in_page_index = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [PAGE_AW-1:0]   out_granted_index;
  logic [CNT_W-1:0]     out_used_count;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_PAGE_COUNT;
  logic [CFG_W-1:0]     cfg_wdata     = '0;

  int          fail_count;
  int          pending_results;
  int          results_checked;
  int          n_alloc, n_free, n_init, n_nop, n_settings;
  int          idle_pct;
  int          cycles;
  // geometry the next init will apply, used to aim free requests
  int unsigned live_pages;
  int unsigned live_rsv;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_page_allocator_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_page_index     (in_page_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_used_count    (out_used_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  bitmap_page_allocator_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_page_index     (in_page_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_used_count    (out_used_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .results_checked   (results_checked)
  );

  // Issue one request, with random idle cycles ahead of it
  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [PAGE_AW-1:0] idx);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= mode;
    in_page_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    case (mode)
      MODE_ALLOC: n_alloc++;
      MODE_FREE:  n_free++;
      MODE_INIT:  n_init++;
      default:    n_nop++;
    endcase
  endtask

  // Hold off until every predicted result has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0 || busy !== 1'b0);
  endtask

  // Write both registers while idle; they act at the next init
  task automatic write_config(input logic [CFG_W-1:0] pages, input logic [CFG_W-1:0] rsv);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAGE_COUNT;
    cfg_wdata <= pages;
    @(posedge clk);
    cfg_index <= CFG_RESERVED;
    cfg_wdata <= rsv;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_pages = (pages > MAX_PAGES) ? MAX_PAGES : pages;
    live_rsv   = (rsv > live_pages) ? live_pages : rsv;
    n_settings++;
  endtask

  // Free targets: mostly near the managed range, some anywhere
  function automatic logic [PAGE_AW-1:0] pick_page();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return PAGE_AW'($urandom_range(live_pages + 1, 0));
    if (r < 75) return PAGE_AW'(live_rsv + $urandom_range(47, 0));
    return PAGE_AW'($urandom);
  endfunction

  task automatic random_req();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      send_req(MODE_ALLOC, PAGE_AW'($urandom));
    else if (r < 85) send_req(MODE_FREE, pick_page());
    else if (r < 90) send_req(MODE_INIT, PAGE_AW'($urandom));
    else             send_req(MODE_NOP, PAGE_AW'($urandom));
  endtask

  // Register setting per random phase: extremes first, then small random maps
  task automatic phase_setting(input int ph, output logic [CFG_W-1:0] pages,
                               output logic [CFG_W-1:0] rsv);
    case (ph)
      0:       begin pages = 13'd4096; rsv = 13'd1;    end
      1:       begin pages = 13'd8;    rsv = 13'd0;    end
      2:       begin pages = 13'd1;    rsv = 13'd0;    end
      3:       begin pages = 13'd4096; rsv = 13'd4090; end
      4:       begin pages = 13'd64;   rsv = 13'd64;   end
      5:       begin pages = 13'd33;   rsv = 13'd2;    end
      6:       begin pages = 13'd100;  rsv = 13'd8191; end
      7:       begin pages = 13'd8191; rsv = 13'd0;    end
      default: begin
        pages = CFG_W'($urandom_range(96, 1));
        rsv   = CFG_W'($urandom_range(pages + 1, 0));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] pages;
    logic [CFG_W-1:0] rsv;
    idle_pct   = 0;
    live_pages = MAX_PAGES;
    live_rsv   = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Default geometry: 4096 pages, page 0 reserved
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, 12'd0);      // reserved page
    send_req(MODE_FREE, 12'd4095);   // never allocated
    send_req(MODE_FREE, 12'd1);
    send_req(MODE_FREE, 12'd1);      // double free
    send_req(MODE_NOP, 12'hFFF);
    send_req(MODE_ALLOC, 12'hFFF);

    // New registers stay dormant until init
    write_config(13'd8, 13'd0);
    send_req(MODE_ALLOC, 12'h5A5);
    send_req(MODE_INIT, 12'hA5A);
    repeat (9) send_req(MODE_ALLOC, '0);   // fill all eight, then full
    send_req(MODE_FREE, 12'd8);            // past the page count
    send_req(MODE_FREE, 12'd5);
    send_req(MODE_ALLOC, '0);              // cursor has wrapped, so page 5 is granted again

    // Zero page count
    write_config(13'd0, 13'd0);
    send_req(MODE_INIT, '0);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, 12'd0);

    // Both registers beyond the map depth saturate
    write_config(13'h1FFF, 13'h1FFF);
    send_req(MODE_INIT, '0);
    send_req(MODE_ALLOC, '0);
    send_req(MODE_FREE, 12'd4095);

    // Random phases, each opened by an init under a fresh setting
    for (int ph = 0; ph < PHASES; ph++) begin
      phase_setting(ph, pages, rsv);
      write_config(pages, rsv);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 75 : 16;
      send_req(MODE_INIT, PAGE_AW'($urandom));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_req();
        if ($urandom_range(49) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d allocate, %0d free, %0d init, %0d no-op)",
             n_alloc + n_free + n_init + n_nop, n_alloc, n_free, n_init, n_nop);
    $display("across %0d register settings; %0d results checked, %0d mismatches",
             n_settings, results_checked, fail_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog on total run length
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_results);
    $display("Test completed with failures");
    $finish;
  end

endmodule
